FILE: sv/fcsg_pkg.sv
// Shared types, constants and tables for the filled-circle span generator.
`timescale 1ns / 1ps

package fcsg_pkg;

  // Most spans kept per circle; later spans are dropped.
  localparam int SpanLimit  = 64;
  // Entries in the job queue between the front and back parts.
  localparam int QueueDepth = 2;

  // One circle request.
  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [4:0]  radius;
    logic [15:0] fill_color;
  } req_t;

  // One fill span.
  typedef struct packed {
    logic [15:0] span_x_start;
    logic [15:0] span_x_end;
    logic [15:0] span_row;
    logic [15:0] span_color;
    logic        last_span;
  } span_t;

  // Classified job handed from the front part to the span walker.
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] color;
    logic [4:0]  r;
    logic [4:0]  imax;
    logic [9:0]  sqmax;
  } job_t;

  // Step count r*707/1000 + 1, tabulated per radius.
  function automatic logic [4:0] imax_of(input logic [4:0] r);
    logic [4:0] v;
    begin
      case (r)
        5'd0:  v = 5'd1;
        5'd1:  v = 5'd1;
        5'd2:  v = 5'd2;
        5'd3:  v = 5'd3;
        5'd4:  v = 5'd3;
        5'd5:  v = 5'd4;
        5'd6:  v = 5'd5;
        5'd7:  v = 5'd5;
        5'd8:  v = 5'd6;
        5'd9:  v = 5'd7;
        5'd10: v = 5'd8;
        5'd11: v = 5'd8;
        5'd12: v = 5'd9;
        5'd13: v = 5'd10;
        5'd14: v = 5'd10;
        5'd15: v = 5'd11;
        5'd16: v = 5'd12;
        5'd17: v = 5'd13;
        5'd18: v = 5'd13;
        5'd19: v = 5'd14;
        5'd20: v = 5'd15;
        5'd21: v = 5'd15;
        5'd22: v = 5'd16;
        5'd23: v = 5'd17;
        5'd24: v = 5'd17;
        5'd25: v = 5'd18;
        5'd26: v = 5'd19;
        5'd27: v = 5'd20;
        5'd28: v = 5'd20;
        5'd29: v = 5'd21;
        5'd30: v = 5'd22;
        default: v = 5'd22;
      endcase
      return v;
    end
  endfunction

endpackage

FILE: sv/fcsg_queue.sv
// Small job queue between the request front part and the span walker.
`timescale 1ns / 1ps

module fcsg_queue import fcsg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  input  logic pop,
  output job_t pop_data,
  output logic full,
  output logic empty
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            slots [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  // Store the incoming job.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track the fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign pop_data = slots[rd_ptr];
  assign full     = (fill == CntW'(QueueDepth));
  assign empty    = (fill == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("job queue read while empty");

endmodule

FILE: sv/fcsg_front.sv
// Request front part: accept circles, drop empty ones, derive walk limits.
`timescale 1ns / 1ps

module fcsg_front import fcsg_pkg::*; (
  input  logic start,
  input  req_t req,
  input  logic queue_full,
  output logic busy,
  output logic push,
  output job_t job
);

  logic       accept;
  logic [9:0] r_sq;

  // Take a request whenever the queue has room.
  assign busy   = queue_full;
  assign accept = start && !queue_full;

  // A zero radius yields no spans, so it never reaches the walker.
  assign push = accept && (req.radius != 5'd0);

  // Walk limits: step count and the x step threshold r*r + r/2.
  assign r_sq = 10'(req.radius) * 10'(req.radius);

  always_comb begin
    job.cx    = req.center_x;
    job.cy    = req.center_y;
    job.color = req.fill_color;
    job.r     = req.radius;
    job.imax  = imax_of(req.radius);
    job.sqmax = r_sq + 10'(req.radius >> 1);
  end

endmodule

FILE: sv/fcsg_back.sv
// Span walker: steps one circle at a time and emits its fill spans.
`timescale 1ns / 1ps

module fcsg_back import fcsg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_empty,
  input  job_t  q_data,
  output logic  pop,
  output span_t span,
  output logic  strobe
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CENTER = 8'b0000_0010,
    S_TEST   = 8'b0000_0100,
    S_OUT_P  = 8'b0000_1000,
    S_OUT_M  = 8'b0001_0000,
    S_IN_P   = 8'b0010_0000,
    S_IN_M   = 8'b0100_0000,
    S_FLUSH  = 8'b1000_0000
  } state_t;

  state_t      state;
  job_t        job;
  logic [4:0]  x;
  logic [4:0]  i;
  logic [6:0]  cnt;
  span_t       pend;
  logic        pend_valid;

  logic [15:0] cand_start;
  logic [15:0] cand_end;
  logic [15:0] cand_row;
  logic [5:0]  cand_len;
  logic        cand_on;
  logic        cand_keep;
  logic [9:0]  i_sq;
  logic [9:0]  x_sq;
  logic [10:0] dist_sq;
  logic        step;
  logic        outer;
  logic        emit;

  assign pop = (state == S_IDLE) && !q_empty;

  // Build the span for the current phase of the walk.
  always_comb begin
    cand_start = job.cx;
    cand_row   = job.cy;
    cand_len   = '0;
    cand_on    = 1'b0;
    unique case (state)
      S_CENTER: begin
        cand_start = job.cx - 16'(job.r);
        cand_row   = job.cy;
        cand_len   = {job.r, 1'b0};
        cand_on    = 1'b1;
      end
      S_OUT_P: begin
        cand_start = job.cx - 16'(i) + 16'd1;
        cand_row   = job.cy + 16'(x);
        cand_len   = {5'(i - 5'd1), 1'b0};
        cand_on    = 1'b1;
      end
      S_OUT_M: begin
        cand_start = job.cx - 16'(i) + 16'd1;
        cand_row   = job.cy - 16'(x);
        cand_len   = {5'(i - 5'd1), 1'b0};
        cand_on    = 1'b1;
      end
      S_IN_P: begin
        cand_start = job.cx - 16'(x);
        cand_row   = job.cy + 16'(i);
        cand_len   = {x, 1'b0};
        cand_on    = 1'b1;
      end
      S_IN_M: begin
        cand_start = job.cx - 16'(x);
        cand_row   = job.cy - 16'(i);
        cand_len   = {x, 1'b0};
        cand_on    = 1'b1;
      end
      S_IDLE, S_TEST, S_FLUSH: begin
        cand_on = 1'b0;
      end
      default: begin
        cand_on = 1'b0;
      end
    endcase
  end

  // Drop empty spans and anything past the span limit.
  assign cand_end  = cand_start + 16'(cand_len) - 16'd1;
  assign cand_keep = cand_on && (cand_len != '0) && (cnt < 7'(SpanLimit));

  // Release the held span when a newer one replaces it or the walk ends.
  assign emit = pend_valid && (cand_keep || (state == S_FLUSH));

  // Step test: i*i + x*x against the threshold.
  assign i_sq    = 10'(i) * 10'(i);
  assign x_sq    = 10'(x) * 10'(x);
  assign dist_sq = {1'b0, i_sq} + {1'b0, x_sq};
  assign step    = dist_sq > {1'b0, job.sqmax};
  assign outer   = step && (x > job.imax);

  // Sequence the walk; hold one span back so the final one can be marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      cnt        <= '0;
    end else begin
      strobe <= emit;
      if (cand_keep) begin
        pend.span_x_start <= cand_start;
        pend.span_x_end   <= cand_end;
        pend.span_row     <= cand_row;
        pend.span_color   <= job.color;
        pend.last_span    <= 1'b0;
        pend_valid        <= 1'b1;
        cnt               <= cnt + 7'd1;
        if (pend_valid) begin
          span <= pend;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job   <= q_data;
            x     <= q_data.r;
            i     <= 5'd1;
            cnt   <= '0;
            state <= S_CENTER;
          end
        end
        S_CENTER: begin
          state <= S_TEST;
        end
        S_TEST: begin
          if (outer) begin
            state <= S_OUT_P;
          end else begin
            if (step && (x != 5'd0)) begin
              x <= x - 5'd1;
            end
            state <= S_IN_P;
          end
        end
        S_OUT_P: begin
          state <= S_OUT_M;
        end
        S_OUT_M: begin
          x     <= x - 5'd1;
          state <= S_IN_P;
        end
        S_IN_P: begin
          state <= S_IN_M;
        end
        S_IN_M: begin
          if (i == job.imax) begin
            state <= S_FLUSH;
          end else begin
            i     <= i + 5'd1;
            state <= S_TEST;
          end
        end
        S_FLUSH: begin
          if (pend_valid) begin
            span <= {pend.span_x_start, pend.span_x_end, pend.span_row,
                     pend.span_color, 1'b1};
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && span.last_span |=> !strobe)
    else $error("span issued right after the final span of a circle");

  a_strobe_from_pend: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(pend_valid))
    else $error("span issued with no held span behind it");

  a_span_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= 7'(SpanLimit))
    else $error("span count ran past the limit");

endmodule

FILE: sv/filled_circle_span_generator.sv
// Top level of the filled-circle span generator: front part, job queue, span walker.
// Each circle occupies the single span walker while i steps from 1 up to imax, where
// imax = r*707/1000 + 1.
// A two-entry job queue lets requests transfer while the walker is still busy.
// Synchronous active-high reset empties the queue and idles the walker; spans never stall.
`timescale 1ns / 1ps

module filled_circle_span_generator import fcsg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  req_t  req,
  output logic  busy,
  output logic  strobe,
  output span_t span
);

  logic push;
  job_t push_job;
  logic pop;
  job_t pop_job;
  logic q_full;
  logic q_empty;

  fcsg_front u_front (
    .start      (start),
    .req        (req),
    .queue_full (q_full),
    .busy       (busy),
    .push       (push),
    .job        (push_job)
  );

  fcsg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .pop       (pop),
    .pop_data  (pop_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  fcsg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (pop_job),
    .pop     (pop),
    .span    (span),
    .strobe  (strobe)
  );

endmodule

FILE: bench/tb_filled_circle_span_generator.sv
// Self-checking testbench for the filled-circle span generator: directed table, random circles.
`timescale 1ns / 1ps

module tb_filled_circle_span_generator;
  import fcsg_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 100;
  localparam int PhaseItems  = 40;

  // One directed row: the request, and a typed-in answer where it is obvious.
  typedef struct packed {
    req_t  rq;
    bit    typed;
    bit    has_span;
    span_t sp;
  } stim_row_t;

  localparam span_t NoSpan = '0;
  localparam int NumRows = 18;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  req = '0;
  logic  busy;
  logic  strobe;
  span_t span;

  span_t     pending_spans[$];
  stim_row_t stim_rows[NumRows];
  int        errors = 0;
  int        idle_pct = 0;
  int        circle_span_cnt;
  int        quiet_cycles = 0;

  filled_circle_span_generator u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .strobe (strobe),
    .span   (span)
  );

  always #6 clk = ~clk;

  // Queue one span of the circle being worked out; drop empty ones and overflow.
  function automatic void emit_span(input int unsigned xs, input int unsigned row,
                                    input int unsigned len, input logic [15:0] color);
    span_t       s;
    logic [15:0] xe;
    if (len == 0 || circle_span_cnt >= SpanLimit) return;
    xe = 16'(xs + len - 1);
    s.span_x_start = xs[15:0];
    s.span_x_end   = xe;
    s.span_row     = row[15:0];
    s.span_color   = color;
    s.last_span    = 1'b0;
    pending_spans.push_back(s);
    circle_span_cnt++;
  endfunction

  // Work out every span of one filled circle, in the order the block emits them.
  function automatic void plot_circle(input req_t rq);
    int unsigned cx, cy, r, imax, sqmax, x, i;
    cx = rq.center_x;
    cy = rq.center_y;
    r  = rq.radius;
    circle_span_cnt = 0;
    if (r == 0) return;
    imax  = (r * 707) / 1000 + 1;
    sqmax = r * r + r / 2;
    x     = r;
    emit_span(cx - r, cy, 2 * r, rq.fill_color);
    for (i = 1; i <= imax; i++) begin
      // step x down once the point leaves the circle; outer rows only above the octant
      if (i * i + x * x > sqmax) begin
        if (x > imax) begin
          emit_span(cx - i + 1, cy + x, 2 * (i - 1), rq.fill_color);
          emit_span(cx - i + 1, cy - x, 2 * (i - 1), rq.fill_color);
        end
        if (x != 0) x--;
      end
      emit_span(cx - x, cy + i, 2 * x, rq.fill_color);
      emit_span(cx - x, cy - i, 2 * x, rq.fill_color);
    end
    if (circle_span_cnt > 0) pending_spans[$].last_span = 1'b1;
  endfunction

  // Pick a coordinate, often close to the wrap point.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(40));
      1: return 16'hFFFF - 16'($urandom_range(40));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic req_t random_circle();
    req_t rq;
    rq.center_x   = pick_coord();
    rq.center_y   = pick_coord();
    rq.fill_color = 16'($urandom);
    case ($urandom_range(9))
      0: rq.radius = 5'd0;
      1: rq.radius = 5'd31;
      2: rq.radius = 5'($urandom_range(3, 1));
      default: rq.radius = 5'($urandom_range(31, 1));
    endcase
    return rq;
  endfunction

  // Present one request, hold it until the transfer, then record its spans.
  task automatic send_circle(input req_t rq, input bit typed, input bit has_span,
                             input span_t sp);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= rq;
    do @(posedge clk); while (busy);
    if (!typed) plot_circle(rq);
    else if (has_span) pending_spans.push_back(sp);
  endtask

  // Hold the sender until every expected span has come back.
  task automatic drain_spans();
    start <= 1'b0;
    @(posedge clk);
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  // Check each span against the oldest expectation.
  always @(posedge clk) begin
    span_t want;
    if (!rst && strobe) begin
      if (pending_spans.size() == 0) begin
        if (errors < 10)
          $display("unexpected span: xs=%h xe=%h row=%h col=%h last=%b",
                   span.span_x_start, span.span_x_end, span.span_row,
                   span.span_color, span.last_span);
        errors++;
      end else begin
        want = pending_spans.pop_front();
        if (span.span_x_start !== want.span_x_start || span.span_x_end !== want.span_x_end ||
            span.span_row !== want.span_row || span.span_color !== want.span_color ||
            span.last_span !== want.last_span) begin
          if (errors < 10)
            $display("span mismatch: exp %h %h %h %h %b, got %h %h %h %h %b",
                     want.span_x_start, want.span_x_end, want.span_row, want.span_color,
                     want.last_span, span.span_x_start, span.span_x_end, span.span_row,
                     span.span_color, span.last_span);
          errors++;
        end
      end
    end
  end

  // End the run when neither side transfers for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("tb_filled_circle_span_generator: done, errors");
      $finish;
    end
  end

  initial begin
    int ph;
    int n;
    int phase_pct[4];
    phase_pct = '{0, 87, 33, 0};
    // zero radius, single-span radius 1 at the wrap points, then sizes for the predictor
    stim_rows = '{
      '{'{16'h1234, 16'h5678, 5'd0,  16'hBEEF}, 1'b1, 1'b0, NoSpan},
      '{'{16'hFFFF, 16'hFFFF, 5'd0,  16'hFFFF}, 1'b1, 1'b0, NoSpan},
      '{'{16'h0000, 16'h0000, 5'd1,  16'h0000}, 1'b1, 1'b1,
        '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1}},
      '{'{16'hFFFF, 16'hFFFF, 5'd1,  16'hFFFF}, 1'b1, 1'b1,
        '{16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}},
      '{'{16'h8000, 16'h7FFF, 5'd1,  16'hA5A5}, 1'b1, 1'b1,
        '{16'h7FFF, 16'h8000, 16'h7FFF, 16'hA5A5, 1'b1}},
      '{'{16'h0100, 16'h0100, 5'd2,  16'h5A5A}, 1'b0, 1'b0, NoSpan},
      '{'{16'h0001, 16'hFFFE, 5'd3,  16'h0F0F}, 1'b0, 1'b0, NoSpan},
      '{'{16'h0000, 16'h0000, 5'd31, 16'h0000}, 1'b0, 1'b0, NoSpan},
      '{'{16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF}, 1'b0, 1'b0, NoSpan},
      '{'{16'h8000, 16'h8000, 5'd31, 16'h8001}, 1'b0, 1'b0, NoSpan},
      '{'{16'h7FF0, 16'h000A, 5'd30, 16'h3C3C}, 1'b0, 1'b0, NoSpan},
      '{'{16'h0010, 16'hFFF0, 5'd16, 16'hC3C3}, 1'b0, 1'b0, NoSpan},
      '{'{16'hFFF0, 16'h0010, 5'd15, 16'h1111}, 1'b0, 1'b0, NoSpan},
      '{'{16'h4000, 16'h2000, 5'd4,  16'h2222}, 1'b0, 1'b0, NoSpan},
      '{'{16'h0005, 16'h0005, 5'd5,  16'h4444}, 1'b0, 1'b0, NoSpan},
      '{'{16'h1000, 16'h1000, 5'd8,  16'h8888}, 1'b0, 1'b0, NoSpan},
      '{'{16'hABCD, 16'h1234, 5'd10, 16'h7777}, 1'b0, 1'b0, NoSpan},
      '{'{16'h0015, 16'hFFEA, 5'd23, 16'hEEEE}, 1'b0, 1'b0, NoSpan}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed table back to back
    foreach (stim_rows[k])
      send_circle(stim_rows[k].rq, stim_rows[k].typed, stim_rows[k].has_span,
                  stim_rows[k].sp);

    // random circles in phases of sender idling, draining between phases
    for (ph = 0; ph < 4; ph++) begin
      drain_spans();
      idle_pct = phase_pct[ph];
      for (n = 0; n < PhaseItems; n++)
        send_circle(random_circle(), 1'b0, 1'b0, NoSpan);
    end

    drain_spans();
    repeat (DrainCycles) @(posedge clk);
    errors += pending_spans.size();
    if (errors == 0) $display("tb_filled_circle_span_generator: done, clean");
    else $display("tb_filled_circle_span_generator: done, errors");
    $finish;
  end

endmodule
